// ----- design/bkv_pkg.sv -----
// Shared types and constants for the byte key-value table.
`default_nettype none
package bkv_pkg;

	// Number of entries the table can hold.
	localparam int CAPACITY = 16;
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = 5;
	localparam int BYTE_W = 8;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// Operation codes.
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_GET = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_DELETE = 2'd3;

	// Status codes.
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_PRESENT = 2'd1;
	localparam logic [1:0] STATUS_ABSENT = 2'd2;
	localparam logic [1:0] STATUS_FULL = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [BYTE_W-1:0] key;
		logic [BYTE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [BYTE_W-1:0] value_out;
		logic [CNT_W-1:0] entry_count;
	} result_t;

	// Memory requests from the sequencer to the key and value memories.
	typedef struct packed {
		logic key_we;
		logic val_we;
		logic [ADDR_W-1:0] waddr;
		logic [ADDR_W-1:0] raddr;
		logic [BYTE_W-1:0] key_wdata;
		logic [BYTE_W-1:0] val_wdata;
	} mem_req_t;

endpackage
`default_nettype wire

// ----- design/bkv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- design/bkv_seq.sv -----
// Sequencer that walks the key memory with one comparator and applies each operation.
`default_nettype none
module bkv_seq (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire bkv_pkg::cmd_t cmd,
	output logic busy,
	output logic done,
	output bkv_pkg::result_t result,
	output bkv_pkg::mem_req_t mem_req,
	input wire logic [bkv_pkg::BYTE_W-1:0] key_rdata,
	input wire logic [bkv_pkg::BYTE_W-1:0] val_rdata
);
	import bkv_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_ACT = 5'b00100,
		S_GETRD = 5'b01000,
		S_MOVE = 5'b10000
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [ADDR_W-1:0] cmp_idx_q;
	logic cmp_v_q;
	logic found_q;
	logic [ADDR_W-1:0] slot_q;
	logic done_q;
	result_t result_q;

	logic hit;
	logic idx_more;
	logic [CNT_W-1:0] last;

	// The one comparator: the key read last cycle against the requested key.
	assign hit = cmp_v_q && (key_rdata == cmd_q.key);
	assign idx_more = idx_q < count_q;
	assign last = count_q - CNT_W'(1);

	always_comb begin
		mem_req = '0;
		mem_req.raddr = idx_q[ADDR_W-1:0];
		mem_req.key_wdata = cmd_q.key;
		mem_req.val_wdata = cmd_q.value;
		case (state_q)
			S_ACT: begin
				case (cmd_q.opcode)
					OP_ADD: begin
						if (!found_q && count_q != CAP_CNT) begin
							mem_req.key_we = 1'b1;
							mem_req.val_we = 1'b1;
							mem_req.waddr = count_q[ADDR_W-1:0];
						end
					end
					OP_GET: begin
						mem_req.raddr = slot_q;
					end
					OP_UPDATE: begin
						mem_req.val_we = found_q;
						mem_req.waddr = slot_q;
					end
					OP_DELETE: begin
						mem_req.raddr = last[ADDR_W-1:0];
					end
					default: begin
					end
				endcase
			end
			S_MOVE: begin
				// Copy the last entry into the freed slot.
				mem_req.key_we = 1'b1;
				mem_req.val_we = 1'b1;
				mem_req.waddr = slot_q;
				mem_req.key_wdata = key_rdata;
				mem_req.val_wdata = val_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			cmp_v_q <= 1'b0;
			found_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					cmp_v_q <= 1'b0;
					if (start) begin
						cmd_q <= cmd;
						idx_q <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
						slot_q <= cmp_idx_q;
						cmp_v_q <= 1'b0;
						state_q <= S_ACT;
					end else if (idx_more) begin
						cmp_idx_q <= idx_q[ADDR_W-1:0];
						cmp_v_q <= 1'b1;
						idx_q <= idx_q + CNT_W'(1);
					end else begin
						cmp_v_q <= 1'b0;
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					result_q.value_out <= '0;
					result_q.entry_count <= count_q;
					result_q.status <= STATUS_OK;
					state_q <= S_IDLE;
					done_q <= 1'b1;
					case (cmd_q.opcode)
						OP_ADD: begin
							if (found_q) begin
								result_q.status <= STATUS_PRESENT;
							end else if (count_q == CAP_CNT) begin
								result_q.status <= STATUS_FULL;
							end else begin
								count_q <= count_q + CNT_W'(1);
								result_q.entry_count <= count_q + CNT_W'(1);
							end
						end
						OP_GET: begin
							if (found_q) begin
								done_q <= 1'b0;
								state_q <= S_GETRD;
							end else begin
								result_q.status <= STATUS_ABSENT;
							end
						end
						OP_UPDATE: begin
							if (!found_q) begin
								result_q.status <= STATUS_ABSENT;
							end
						end
						OP_DELETE: begin
							if (found_q) begin
								done_q <= 1'b0;
								state_q <= S_MOVE;
							end else begin
								result_q.status <= STATUS_ABSENT;
							end
						end
						default: begin
						end
					endcase
				end
				S_GETRD: begin
					result_q.value_out <= val_rdata;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_MOVE: begin
					count_q <= last;
					result_q.entry_count <= last;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ----- design/byte_key_value_table.sv -----
// Top level of the byte key-value table: sequencer plus key and value memories.
`default_nettype none
// A table of up to CAPACITY byte keys with one byte value each, searched
// linearly from entry 0 upward by a single key comparator. A command transfer
// happens at a rising edge where start is high and busy is low; busy then stays
// high until the command is finished. The comparator walks the key memory one
// entry per clock, up to the match (all stored entries on a miss), then the
// command is applied. A get that finds its key then reads the value memory,
// and a delete that finds its key then copies the last entry into the freed
// slot. The longest command is therefore a get or delete that matches the last
// entry of a full table of 16. Each command produces exactly one result
// transfer: done is high for a single cycle, the first idle cycle, with status,
// value_out and entry_count on result. The receiver cannot hold it off, so it
// must capture the result in that cycle. A new command may be started in the
// same cycle that done is shown. Delete moves the last entry into the freed
// slot, so entry order changes after a delete.
module byte_key_value_table (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire bkv_pkg::cmd_t cmd,
	output logic busy,
	output logic done,
	output bkv_pkg::result_t result
);
	import bkv_pkg::*;

	mem_req_t mem_req;
	logic [BYTE_W-1:0] key_rdata;
	logic [BYTE_W-1:0] val_rdata;

	// The sequencer owns the entry count, the scan index and the result register.
	bkv_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result),
		.mem_req(mem_req),
		.key_rdata(key_rdata),
		.val_rdata(val_rdata)
	);

	// Keys and values live in two memories that share their addresses.
	bkv_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(CAPACITY)
	) u_key_ram (
		.clk(clk),
		.we(mem_req.key_we),
		.waddr(mem_req.waddr),
		.wdata(mem_req.key_wdata),
		.raddr(mem_req.raddr),
		.rdata(key_rdata)
	);

	bkv_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(CAPACITY)
	) u_val_ram (
		.clk(clk),
		.we(mem_req.val_we),
		.waddr(mem_req.waddr),
		.wdata(mem_req.val_wdata),
		.raddr(mem_req.raddr),
		.rdata(val_rdata)
	);

	// A started command always makes the block busy on the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// A result is only shown once the sequencer has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	// The entry count never exceeds the capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.entry_count <= CAP_CNT)
		else $error("entry count above capacity");

	// A full status is only reported when the table really is full.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == STATUS_FULL |-> result.entry_count == CAP_CNT)
		else $error("full status with free entries");

	// Failed commands never return a value.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != STATUS_OK |-> result.value_out == '0)
		else $error("value returned by a failed command");

endmodule
`default_nettype wire

// ----- tb/tb_byte_key_value_table.sv -----
// Self-checking testbench for the byte key-value table: directed and random commands.
`timescale 1ns / 100ps
module tb_byte_key_value_table;
	import bkv_pkg::*;

	// Run limit in clock cycles. The slowest correct run is about 1050 commands,
	// each at its longest busy time plus the widest gap, and this is about ten
	// times that.
	localparam int CYCLE_LIMIT = 400000;
	// Cycles allowed after the last result before the verdict.
	localparam int TAIL_CYCLES = 40;
	// Keys drawn from a small pool so that hits, a full table and misses all occur.
	localparam int POOL_SIZE = 24;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 103;

	// Traffic mix of a random phase.
	typedef enum int {MIX_FILL, MIX_BALANCED, MIX_EMPTY} mix_t;
	// How the sender spaces its commands.
	typedef enum int {GAPS_NONE, GAPS_RANDOM, GAPS_SPARSE} gap_style_t;

	// One command waiting to be sent, with the idle cycles before it and
	// whether the sender first waits for every outstanding result.
	typedef struct {
		cmd_t c;
		int unsigned gap;
		bit settle_first;
	} queued_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	result_t result;

	queued_cmd_t cmd_backlog[$];
	result_t predicted_results[$];

	// The testbench's own copy of the table.
	logic [BYTE_W-1:0] shadow_keys [CAPACITY];
	logic [BYTE_W-1:0] shadow_vals [CAPACITY];
	int unsigned shadow_count = 0;

	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	logic took = 1'b0;
	int unsigned wait_left = 0;
	bit gap_armed = 1'b0;
	gap_style_t gap_style = GAPS_RANDOM;
	logic [BYTE_W-1:0] key_pool [POOL_SIZE];

	byte_key_value_table u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Applies one command to the shadow table and returns the result the block
	// should report. The search is linear from entry 0, first match wins.
	function automatic result_t table_apply(cmd_t c);
		result_t r;
		int slot;
		int unsigned last;
		r = '0;
		slot = -1;
		for (int i = 0; i < int'(shadow_count); i++) begin
			if (slot < 0 && shadow_keys[i] == c.key) begin
				slot = i;
			end
		end
		r.status = STATUS_OK;
		case (c.opcode)
			OP_ADD: begin
				// Presence is checked before fullness.
				if (slot >= 0) begin
					r.status = STATUS_PRESENT;
				end else if (shadow_count >= CAPACITY) begin
					r.status = STATUS_FULL;
				end else begin
					shadow_keys[shadow_count] = c.key;
					shadow_vals[shadow_count] = c.value;
					shadow_count++;
				end
			end
			OP_GET: begin
				if (slot < 0) begin
					r.status = STATUS_ABSENT;
				end else begin
					r.value_out = shadow_vals[slot];
				end
			end
			OP_UPDATE: begin
				if (slot < 0) begin
					r.status = STATUS_ABSENT;
				end else begin
					shadow_vals[slot] = c.value;
				end
			end
			default: begin
				// Delete: the last entry moves into the freed slot.
				if (slot < 0) begin
					r.status = STATUS_ABSENT;
				end else begin
					last = shadow_count - 1;
					shadow_keys[slot] = shadow_keys[last];
					shadow_vals[slot] = shadow_vals[last];
					shadow_count = last;
				end
			end
		endcase
		r.entry_count = CNT_W'(shadow_count);
		return r;
	endfunction

	function automatic int unsigned draw_gap();
		int unsigned g;
		case (gap_style)
			GAPS_NONE: g = 0;
			GAPS_SPARSE: g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
			default: g = $urandom_range(0, 15);
		endcase
		return g;
	endfunction

	task automatic queue_cmd(logic [1:0] op, logic [BYTE_W-1:0] k,
			logic [BYTE_W-1:0] v, bit settle);
		queued_cmd_t q;
		q.c.opcode = op;
		q.c.key = k;
		q.c.value = v;
		q.gap = draw_gap();
		q.settle_first = settle;
		cmd_backlog.push_back(q);
	endtask

	function automatic logic [1:0] pick_op(mix_t mix);
		int unsigned r;
		logic [1:0] op;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: op = (r < 55) ? OP_ADD : (r < 70) ? OP_GET :
					(r < 85) ? OP_UPDATE : OP_DELETE;
			MIX_EMPTY: op = (r < 20) ? OP_ADD : (r < 40) ? OP_GET :
					(r < 55) ? OP_UPDATE : OP_DELETE;
			default: op = logic'(r[0]) ? (r < 50 ? OP_ADD : OP_GET) :
					(r < 50 ? OP_UPDATE : OP_DELETE);
		endcase
		return op;
	endfunction

	// Transfer detection, prediction and result checking all happen on the
	// rising edge, using values that were settled since the falling edge.
	always @(posedge clk) begin : monitor
		result_t want;
		took <= arst_n && start && !busy;
		if (arst_n && start && !busy) begin
			predicted_results.push_back(table_apply(cmd));
		end
		// A new command may be accepted in the same cycle a result is shown;
		// its expectation sits behind the older one, so the order holds.
		if (arst_n && done) begin
			if (predicted_results.size() == 0) begin
				$error("result with nothing expected: status %0d value_out %0d entry_count %0d",
						result.status, result.value_out, result.entry_count);
				fail_count++;
			end else begin
				want = predicted_results.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, result.status);
					fail_count++;
				end
				if (result.value_out !== want.value_out) begin
					$error("value_out: expected %0d, actual %0d",
							want.value_out, result.value_out);
					fail_count++;
				end
				if (result.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, actual %0d",
							want.entry_count, result.entry_count);
					fail_count++;
				end
			end
		end
	end

	// The sender works on the falling edge. It drops start after a transfer
	// unless the next command is due at once, in which case start stays high
	// and only the payload changes.
	always @(negedge clk) begin : driver
		logic nxt_start;
		cmd_t nxt_cmd;
		nxt_start = start;
		nxt_cmd = cmd;
		if (arst_n) begin
			if (took) begin
				nxt_start = 1'b0;
			end
			if (!nxt_start && cmd_backlog.size() > 0) begin
				if (!gap_armed) begin
					wait_left = cmd_backlog[0].gap;
					gap_armed = 1'b1;
				end
				if (wait_left > 0) begin
					wait_left--;
				end else if (!cmd_backlog[0].settle_first ||
						(predicted_results.size() == 0 && !took && !busy)) begin
					nxt_start = 1'b1;
					nxt_cmd = cmd_backlog[0].c;
					void'(cmd_backlog.pop_front());
					gap_armed = 1'b0;
				end
			end
		end
		start <= nxt_start;
		cmd <= nxt_cmd;
	end

	initial begin : stimulus
		mix_t mix;
		logic [BYTE_W-1:0] k;

		// Directed part: misses on an empty table, a duplicate add, filling to
		// capacity with keys 1 and 255 among them, both full-table add cases, hits,
		// and a delete of the first entry that moves the last one down.
		gap_style = GAPS_RANDOM;
		queue_cmd(OP_GET, 8'd1, 8'd0, 1'b0);
		queue_cmd(OP_UPDATE, 8'd255, 8'd255, 1'b0);
		queue_cmd(OP_DELETE, 8'd128, 8'd0, 1'b0);
		queue_cmd(OP_ADD, 8'd1, 8'd0, 1'b0);
		queue_cmd(OP_ADD, 8'd1, 8'd77, 1'b0);
		queue_cmd(OP_ADD, 8'd255, 8'd255, 1'b0);
		for (int i = 2; i < CAPACITY; i++) begin
			queue_cmd(OP_ADD, BYTE_W'(16 * i + 3), BYTE_W'(i * 17), 1'b0);
		end
		queue_cmd(OP_ADD, 8'd2, 8'd5, 1'b0);
		queue_cmd(OP_ADD, 8'd255, 8'd0, 1'b0);
		queue_cmd(OP_GET, 8'd255, 8'd0, 1'b0);
		queue_cmd(OP_UPDATE, 8'd1, 8'd170, 1'b1);
		queue_cmd(OP_GET, 8'd1, 8'd0, 1'b0);
		queue_cmd(OP_DELETE, 8'd1, 8'd0, 1'b0);
		queue_cmd(OP_GET, BYTE_W'(16 * (CAPACITY - 1) + 3), 8'd0, 1'b0);
		queue_cmd(OP_GET, 8'd1, 8'd0, 1'b0);

		// Random phases alternate between filling, balanced and emptying mixes,
		// each over its own key pool and spacing style. Every phase opens by
		// letting the table settle so gaps also land right after idle.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			mix = mix_t'(p % 3);
			gap_style = gap_style_t'($urandom_range(0, 2));
			foreach (key_pool[i]) begin
				key_pool[i] = BYTE_W'($urandom_range(1, 255));
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 4) == 0) begin
					k = BYTE_W'($urandom_range(1, 255));
				end else begin
					k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
				end
				queue_cmd(pick_op(mix), k, BYTE_W'($urandom_range(0, 255)), n == 0);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (cmd_backlog.size() == 0 && !start);
		wait (predicted_results.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("byte_key_value_table test passed");
		end else begin
			$display("byte_key_value_table test failed");
		end
		$finish;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("byte_key_value_table test failed");
		$finish;
	end

endmodule
